[rtl/rss_pkg.sv]
package rss_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    typedef struct packed {
        logic signed [31:0] record_id;
        logic signed [31:0] record_grade;
        logic               batch_end;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] sorted_id;
        logic signed [31:0] sorted_grade;
        logic               sorted_last;
    } out_word_t;

    // Store layout: grade in the upper half, identifier in the lower half.
    typedef struct packed {
        logic signed [31:0] grade;
        logic signed [31:0] id;
    } record_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        record_t           wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT,
        ST_SWAP
    } sort_state_t;

    localparam logic KEY_ID    = 1'b0;
    localparam logic KEY_GRADE = 1'b1;

    // Signed strict less-than on the low KEY_WIDTH bits of the selected field.
    function automatic logic key_less(record_t a, record_t b, logic sel);
        logic signed [KEY_WIDTH-1:0] ka;
        logic signed [KEY_WIDTH-1:0] kb;
        ka = (sel == KEY_GRADE) ? a.grade[KEY_WIDTH-1:0] : a.id[KEY_WIDTH-1:0];
        kb = (sel == KEY_GRADE) ? b.grade[KEY_WIDTH-1:0] : b.id[KEY_WIDTH-1:0];
        return ka < kb;
    endfunction

endpackage

[rtl/rss_ram.sv]
module rss_ram (
    input  logic             aclk,
    input  rss_pkg::mem_req_t req,
    output rss_pkg::record_t  rd_data
);
    import rss_pkg::*;

    record_t mem [MAX_RECORDS];
    record_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rss_ctrl.sv]
module rss_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rss_pkg::in_word_t  s_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    output rss_pkg::mem_req_t  mem_req,
    input  rss_pkg::record_t   mem_rd_data,
    input  logic               out_free,
    output logic               emit_valid,
    output rss_pkg::out_word_t emit_word
);
    import rss_pkg::*;

    sort_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] last_idx_reg, last_idx_next;
    logic [ADDR_W-1:0] pass_reg, pass_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [ADDR_W-1:0] min_idx_reg, min_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              issue_done_reg, issue_done_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              sort_key_reg, sort_key_next;
    logic              key_sel_reg, key_sel_next;
    record_t           min_rec_reg, min_rec_next;
    record_t           head_rec_reg, head_rec_next;

    logic batch_done;
    logic scan_last;

    // A record that fills the last free entry closes the batch.
    assign batch_done = s_data.batch_end || (count_reg == CNT_W'(MAX_RECORDS - 1));
    assign scan_last  = rd_pend_reg && (rd_idx_reg == last_idx_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid && batch_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP: begin
                state_next = (pass_reg == last_idx_reg) ? ST_LOAD : ST_SCAN;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        last_idx_next   = last_idx_reg;
        pass_next       = pass_reg;
        scan_next       = scan_reg;
        min_idx_next    = min_idx_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        rd_pend_next    = 1'b0;
        sort_key_next   = cfg_wr_en ? cfg_wr_data : sort_key_reg;
        key_sel_next    = key_sel_reg;
        min_rec_next    = min_rec_reg;
        head_rec_next   = head_rec_reg;
        s_ready         = 1'b0;
        emit_valid      = 1'b0;
        mem_req         = '0;

        emit_word.sorted_id    = min_rec_reg.id;
        emit_word.sorted_grade = min_rec_reg.grade;
        emit_word.sorted_last  = (pass_reg == last_idx_reg);

        case (state_reg)
            ST_LOAD: begin
                s_ready            = 1'b1;
                mem_req.wr_addr    = count_reg[ADDR_W-1:0];
                mem_req.wr_data.id    = s_data.record_id;
                mem_req.wr_data.grade = s_data.record_grade;
                if (s_valid) begin
                    mem_req.wr_en = 1'b1;
                    if (batch_done) begin
                        last_idx_next   = count_reg[ADDR_W-1:0];
                        count_next      = '0;
                        pass_next       = '0;
                        scan_next       = '0;
                        issue_done_next = 1'b0;
                        key_sel_next    = sort_key_reg;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                // Reads stream out one per cycle; each result comes back in the following cycle.
                if (!issue_done_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg;
                    rd_pend_next    = 1'b1;
                    rd_idx_next     = scan_reg;
                    if (scan_reg == last_idx_reg) begin
                        issue_done_next = 1'b1;
                    end else begin
                        scan_next = scan_reg + ADDR_W'(1);
                    end
                end
                if (rd_pend_reg) begin
                    if (rd_idx_reg == pass_reg) begin
                        min_rec_next  = mem_rd_data;
                        head_rec_next = mem_rd_data;
                        min_idx_next  = pass_reg;
                    end else if (key_less(mem_rd_data, min_rec_reg, key_sel_reg)) begin
                        min_rec_next = mem_rd_data;
                        min_idx_next = rd_idx_reg;
                    end
                end
            end
            ST_EMIT: begin
                // The minimum of this pass is final at the head position.
                mem_req.wr_addr = pass_reg;
                mem_req.wr_data = min_rec_reg;
                if (out_free) begin
                    emit_valid    = 1'b1;
                    mem_req.wr_en = 1'b1;
                end
            end
            ST_SWAP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = min_idx_reg;
                mem_req.wr_data = head_rec_reg;
                pass_next       = pass_reg + ADDR_W'(1);
                scan_next       = pass_reg + ADDR_W'(1);
                issue_done_next = 1'b0;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            last_idx_reg   <= '0;
            pass_reg       <= '0;
            scan_reg       <= '0;
            min_idx_reg    <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            sort_key_reg   <= KEY_ID;
            key_sel_reg    <= KEY_ID;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_idx_reg   <= last_idx_next;
            pass_reg       <= pass_next;
            scan_reg       <= scan_next;
            min_idx_reg    <= min_idx_next;
            rd_idx_reg     <= rd_idx_next;
            issue_done_reg <= issue_done_next;
            rd_pend_reg    <= rd_pend_next;
            sort_key_reg   <= sort_key_next;
            key_sel_reg    <= key_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_rec_reg  <= min_rec_next;
        head_rec_reg <= head_rec_next;
    end

endmodule

[rtl/record_selection_sorter.sv]
// Records load at one word per cycle outside a sort; the word that ends a batch starts
// the sort. For a batch of n records, pass p scans entries p to n-1 through the single
// read port of the record memory, then emits the minimum and swaps it into place.
// The first sorted word enters the output register when the first pass emits.
// Synchronous active-low reset clears control and the sort key; memory is not cleared.
module record_selection_sorter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rss_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rss_pkg::out_word_t m_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);
    import rss_pkg::*;

    mem_req_t  mem_req;
    record_t   mem_rd_data;
    logic      out_free;
    logic      emit_valid;
    out_word_t emit_word;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    rss_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    rss_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .out_free    (out_free),
        .emit_valid  (emit_valid),
        .emit_word   (emit_word)
    );

    // Output register: a new word may enter as the held one is taken.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            m_valid_next = emit_valid;
            m_data_next  = emit_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid |-> out_free)
        else $error("sorted word emitted while output register is occupied");

    a_no_load_during_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid |-> !s_ready)
        else $error("input accepted while a sort is emitting");

    a_gap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.sorted_last) |=> !m_valid)
        else $error("word presented right after the last word of a batch");
`endif

endmodule
